>>> rtl/pidc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants of the two-mode PID controller: configuration
// bundle, register map and reset values.
// ----------------------------------------------------------------------------
package pidc_pkg;

	// Default number of fraction bits in the Q-format gains
	localparam int unsigned GFB_DEFAULT = 8;

	// APB register map, register index = paddr[4:2]
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned PADDR_W   = 5;

	localparam logic [REG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KP          = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KI          = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KD          = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ILIMIT      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd5;

	// Operating modes
	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

	// Input commands
	localparam logic CMD_RUN   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Reset values
	localparam logic [19:0]        ILIMIT_RESET = 20'hF_FFFF;
	localparam logic signed [31:0] UPPER_RESET  = 32'sd6000;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] kp;
		logic signed [15:0] ki;
		logic signed [15:0] kd;
		logic [19:0]        ilimit;
		logic signed [31:0] upper_limit;
	} pidc_cfg_t;

endpackage : pidc_pkg
`default_nettype wire

>>> rtl/pidc_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_regs
// APB configuration registers of the PID controller.
// ----------------------------------------------------------------------------
module pidc_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pidc_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output pidc_pkg::pidc_cfg_t                cfg
);
	import pidc_pkg::*;

	pidc_cfg_t              cfg_q;
	logic [REG_IDX_W-1:0]   idx;
	logic                   wr_en;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_POSITIONAL;
			cfg_q.kp          <= '0;
			cfg_q.ki          <= '0;
			cfg_q.kd          <= '0;
			cfg_q.ilimit      <= ILIMIT_RESET;
			cfg_q.upper_limit <= UPPER_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MODE:        cfg_q.mode        <= pwdata[0];
				REG_KP:          cfg_q.kp          <= pwdata[15:0];
				REG_KI:          cfg_q.ki          <= pwdata[15:0];
				REG_KD:          cfg_q.kd          <= pwdata[15:0];
				REG_ILIMIT:      cfg_q.ilimit      <= pwdata[19:0];
				REG_UPPER_LIMIT: cfg_q.upper_limit <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:        prdata = {31'd0, cfg_q.mode};
			REG_KP:          prdata = 32'(cfg_q.kp);
			REG_KI:          prdata = 32'(cfg_q.ki);
			REG_KD:          prdata = 32'(cfg_q.kd);
			REG_ILIMIT:      prdata = {12'd0, cfg_q.ilimit};
			REG_UPPER_LIMIT: prdata = cfg_q.upper_limit;
			default:         prdata = '0;
		endcase
	end

endmodule : pidc_regs
`default_nettype wire

>>> rtl/pidc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_core
// Controller state and the combinational step datapath: three shared gain
// multipliers, integral clamp, output clamp and saturation.
// ----------------------------------------------------------------------------
module pidc_core #(
	parameter int unsigned GAIN_FRACTION_BITS = pidc_pkg::GFB_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pidc_pkg::pidc_cfg_t   cfg,
	input  wire logic                  step,
	input  wire logic                  cmd,
	input  wire logic signed [16:0]    err,
	output logic signed [31:0]         drive_nxt,
	output logic                       clamped_nxt
);
	import pidc_pkg::*;

	localparam int ACC_W = 32 + GAIN_FRACTION_BITS;
	localparam int SUM_W = ((ACC_W > 38) ? ACC_W : 38) + 2;

	logic signed [16:0]      e1_q, e2_q;
	logic signed [21:0]      esum_q;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [22:0]      isum, lim_pos, lim_neg, isum_clip;
	logic                    iclamp;
	logic signed [21:0]      esum_nxt;
	logic signed [17:0]      d1;
	logic signed [19:0]      dd;
	logic signed [17:0]      opnd_p;
	logic signed [21:0]      opnd_i;
	logic signed [19:0]      opnd_d;
	logic signed [33:0]      prod_p;
	logic signed [37:0]      prod_i;
	logic signed [35:0]      prod_d;
	logic signed [SUM_W-1:0] total, shifted, upper_w, lower_w, acc_lo, acc_new;
	logic signed [SUM_W-1:0] max_w, min_w, acc_shifted;
	logic                    lo_hit, hi_hit;
	logic signed [31:0]      drive_pos;

	// Integral path with symmetric clamp
	assign isum    = 23'(esum_q) + 23'(err);
	assign lim_pos = $signed({3'b000, cfg.ilimit});
	assign lim_neg = -lim_pos;

	always_comb begin
		iclamp    = 1'b0;
		isum_clip = isum;
		if (isum > lim_pos) begin
			isum_clip = lim_pos;
			iclamp    = 1'b1;
		end else if (isum < lim_neg) begin
			isum_clip = lim_neg;
			iclamp    = 1'b1;
		end
	end
	assign esum_nxt = 22'(isum_clip);

	// First and second error differences
	assign d1 = 18'(err) - 18'(e1_q);
	assign dd = 20'(err) - (20'(e1_q) <<< 1) + 20'(e2_q);

	// Operand select: the same three multipliers serve both modes
	assign opnd_p = (cfg.mode == MODE_INCREMENTAL) ? d1 : 18'(err);
	assign opnd_i = (cfg.mode == MODE_INCREMENTAL) ? 22'(err) : esum_nxt;
	assign opnd_d = (cfg.mode == MODE_INCREMENTAL) ? dd : 20'(d1);

	assign prod_p = opnd_p * cfg.kp;
	assign prod_i = opnd_i * cfg.ki;
	assign prod_d = opnd_d * cfg.kd;

	assign total = ((cfg.mode == MODE_INCREMENTAL) ? SUM_W'(acc_q) : SUM_W'(0))
		+ SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

	// Positional: drop fraction bits (floor) and saturate to 32 bits
	assign max_w   = SUM_W'(32'sh7FFF_FFFF);
	assign min_w   = SUM_W'(32'sh8000_0000);
	assign shifted = total >>> GAIN_FRACTION_BITS;

	always_comb begin
		if (shifted > max_w)
			drive_pos = 32'sh7FFF_FFFF;
		else if (shifted < min_w)
			drive_pos = 32'sh8000_0000;
		else
			drive_pos = 32'(shifted);
	end

	// Incremental: lower saturation first, upper clamp wins
	assign upper_w = SUM_W'(cfg.upper_limit) <<< GAIN_FRACTION_BITS;
	assign lower_w = min_w <<< GAIN_FRACTION_BITS;
	assign lo_hit  = total < lower_w;
	assign acc_lo  = lo_hit ? lower_w : total;
	assign hi_hit  = acc_lo > upper_w;
	assign acc_new = hi_hit ? upper_w : acc_lo;
	assign acc_shifted = acc_new >>> GAIN_FRACTION_BITS;

	always_comb begin
		if (cmd == CMD_CLEAR) begin
			drive_nxt   = '0;
			clamped_nxt = 1'b0;
		end else if (cfg.mode == MODE_INCREMENTAL) begin
			drive_nxt   = 32'(acc_shifted);
			clamped_nxt = lo_hit | hi_hit;
		end else begin
			drive_nxt   = drive_pos;
			clamped_nxt = iclamp;
		end
	end

	// Advance the stored errors, the error sum and the accumulated output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q   <= '0;
			e2_q   <= '0;
			esum_q <= '0;
			acc_q  <= '0;
		end else if (step) begin
			if (cmd == CMD_CLEAR) begin
				e1_q   <= '0;
				e2_q   <= '0;
				esum_q <= '0;
				acc_q  <= '0;
			end else if (cfg.mode == MODE_INCREMENTAL) begin
				acc_q <= ACC_W'(acc_new);
				e2_q  <= e1_q;
				e1_q  <= err;
			end else begin
				esum_q <= esum_nxt;
				e1_q   <= err;
			end
		end
	end

endmodule : pidc_core
`default_nettype wire

>>> rtl/pid_controller_two_mode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_two_mode
// PID regulator with positional and incremental modes, Q-format gains and an
// APB configuration port.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled
// and returns one result item for each: the error is captured in an input
// register, and the step (three gain multiplies, sum, clamps and saturation)
// is then registered into the result register, where the controller state
// is updated at the same edge so the next item sees it at once. A stalled
// output holds the result register; the input register then still takes one
// more item. A clear command (cmd = 1) zeroes the stored errors, the error
// sum and the accumulated output, and returns drive 0 with clamped 0. The
// integral clamp applies in positional mode, the output upper clamp and the
// lower saturation at -2^31 in incremental mode; each mode keeps its own
// stored value, and both share the previous error. Write the registers only
// while no item is in flight. Register map (32-bit, byte address =
// 4*index): mode, proportional_gain, integral_gain, derivative_gain,
// integral_limit, output_upper_limit. There is no post-reset clearing pass.
// ----------------------------------------------------------------------------
module pid_controller_two_mode #(
	parameter int unsigned GAIN_FRACTION_BITS = pidc_pkg::GFB_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pidc_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	// Input items
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          cmd,
	input  wire logic signed [15:0]            setpoint,
	input  wire logic signed [15:0]            measurement,
	// Result items
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [31:0]                 drive,
	output logic                               clamped
);
	import pidc_pkg::*;

	pidc_cfg_t          cfg;

	logic               valid_s1;
	logic               cmd_s1;
	logic signed [16:0] err_s1;

	logic               out_valid_q;
	logic signed [31:0] drive_q;
	logic               clamped_q;

	logic               advance;
	logic signed [31:0] drive_nxt;
	logic               clamped_nxt;

	pidc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Move the input stage forward whenever the result register is free or drains now
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	// Input register: capture the command and the error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= cmd;
			err_s1 <= 17'(setpoint) - 17'(measurement);
		end
	end

	// Step datapath and controller state, updated on advance
	pidc_core #(
		.GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (advance),
		.cmd         (cmd_s1),
		.err         (err_s1),
		.drive_nxt   (drive_nxt),
		.clamped_nxt (clamped_nxt)
	);

	// Result register: hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q   <= drive_nxt;
			clamped_q <= clamped_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clamped   = clamped_q;

endmodule : pid_controller_two_mode
`default_nettype wire
